// ===== rtl/core/joystick_deadzone_ramp_limiter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Joystick deadzone and ramp limiter: assertion macros
// Concurrent assertion forms for the limiter's top-level RTL.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_DEADZONE_RAMP_LIMITER_UNIT_DEFINES_SVH
`define JOYSTICK_DEADZONE_RAMP_LIMITER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JDRL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define JDRL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle property failed");

`endif

// ===== rtl/core/jdrl_pkg.sv =====
// ----------------------------------------------------------------------------
// jdrl_pkg
// Types and constants shared by the joystick deadzone and ramp limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package jdrl_pkg;

   // Q1.15 saturation limit.
   localparam logic [14:0] QMAX = 15'h7FFF;

   // Register indexes (byte address divided by four).
   localparam logic [2:0] REG_DEADZONE_XY   = 3'd0;
   localparam logic [2:0] REG_DEADZONE_TURN = 3'd1;
   localparam logic [2:0] REG_MAX_TURN      = 3'd2;
   localparam logic [2:0] REG_ACCEL         = 3'd3;
   localparam logic [2:0] REG_MIN_Y_SPEED   = 3'd4;

   // Register reset values.
   localparam logic [14:0] RST_DEADZONE_XY   = 15'd3277;
   localparam logic [14:0] RST_DEADZONE_TURN = 15'd4915;
   localparam logic [14:0] RST_MAX_TURN      = 15'd16384;
   localparam logic [14:0] RST_ACCEL         = 15'd3277;
   localparam logic [14:0] RST_MIN_Y_SPEED   = 15'd9830;

   // Sequencing strobes from the top level to every lane.
   typedef struct packed {
      logic load;    // capture the governor product of a new item
      logic commit;  // finish the ramp and update the stored speed
   } lane_ctrl_type;

   // Register values one lane works with.
   typedef struct packed {
      logic [14:0] deadzone;
      logic [14:0] max_turn;
      logic [14:0] accel;
      logic [14:0] min_speed;
   } lane_cfg_type;

   // What one lane finds for its axis.
   typedef struct packed {
      logic signed [15:0] cond;
      logic signed [15:0] ramped;
   } lane_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/joystick_deadzone_ramp_limiter_unit.sv =====
// ----------------------------------------------------------------------------
// joystick_deadzone_ramp_limiter_unit
// Conditions three joystick axes (deadzone, governor, clamp on x and turn) and limits the
// acceleration of each, one lane per axis, with registers on an APB port.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     x_cmd, y_cmd, turn_cmd, governor
//   rsp      out        rsp_valid/stall     three conditioned, three ramped
//   csr      in/out     psel/penable/ready  five 15-bit registers at 4*i
//
// For each item the governor product, rounded, saturated and clamped, is
// registered at the transfer edge, and the accel multiply and ramp finish
// at the commit. A new item is taken only once the last one has committed;
// the stored speeds close the loop per item. A finished item waits in its lane
// registers while the result register is held by rsp_stall. Reset is
// synchronous, clears the stored speeds and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

`include "joystick_deadzone_ramp_limiter_unit_defines.svh"

module joystick_deadzone_ramp_limiter_unit
   import jdrl_pkg::*;
#(
   parameter int FRAC_BITS = 15
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [15:0] req_x_cmd,
   input  wire logic signed [15:0] req_y_cmd,
   input  wire logic signed [15:0] req_turn_cmd,
   input  wire logic [14:0]        req_governor,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_x_conditioned,
   output logic signed [15:0]      rsp_y_conditioned,
   output logic signed [15:0]      rsp_turn_conditioned,
   output logic signed [15:0]      rsp_x_ramped,
   output logic signed [15:0]      rsp_y_ramped,
   output logic signed [15:0]      rsp_turn_ramped,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [4:0]         csr_paddr,
   input  wire logic [31:0]        csr_pwdata,
   output logic [31:0]             csr_prdata,
   output logic                    csr_pready
);

   localparam int FW = FRAC_BITS + 1;
   localparam int GW = (FW > 16) ? FW : 16;
   localparam logic [GW-1:0] ONE = {{(GW-1){1'b0}}, 1'b1} << FRAC_BITS;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CALC = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [14:0]   dz_xy_ff, dz_turn_ff, max_turn_ff, accel_ff, min_y_ff;
   logic          accept;
   logic          csr_write;
   logic [GW-1:0] gov_ext;
   logic [GW-1:0] factor_full;
   logic [FW-1:0] factor;
   lane_ctrl_type ctrl;
   lane_cfg_type  cfg_xy, cfg_y, cfg_turn;
   lane_out_type  out_x, out_y, out_turn;

   // Register port: writes on the access phase, reads return the value.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_xy_ff    <= RST_DEADZONE_XY;
         dz_turn_ff  <= RST_DEADZONE_TURN;
         max_turn_ff <= RST_MAX_TURN;
         accel_ff    <= RST_ACCEL;
         min_y_ff    <= RST_MIN_Y_SPEED;
      end else if (csr_write) begin
         unique case (csr_paddr[4:2])
            REG_DEADZONE_XY:   dz_xy_ff    <= csr_pwdata[14:0];
            REG_DEADZONE_TURN: dz_turn_ff  <= csr_pwdata[14:0];
            REG_MAX_TURN:      max_turn_ff <= csr_pwdata[14:0];
            REG_ACCEL:         accel_ff    <= csr_pwdata[14:0];
            REG_MIN_Y_SPEED:   min_y_ff    <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[4:2])
         REG_DEADZONE_XY:   csr_prdata = {17'd0, dz_xy_ff};
         REG_DEADZONE_TURN: csr_prdata = {17'd0, dz_turn_ff};
         REG_MAX_TURN:      csr_prdata = {17'd0, max_turn_ff};
         REG_ACCEL:         csr_prdata = {17'd0, accel_ff};
         REG_MIN_Y_SPEED:   csr_prdata = {17'd0, min_y_ff};
         default:           csr_prdata = 32'd0;
      endcase
   end

   // Sequencer: take an item, then commit it once the result register frees.
   assign req_stall   = (state_ff != ST_IDLE);
   assign accept      = req_valid & ~req_stall;
   assign ctrl.load   = accept;
   assign ctrl.commit = (state_ff == ST_CALC) & (~rsp_valid | ~rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_CALC;
         ST_CALC: if (ctrl.commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Governor factor 1.0 - governor, floored at zero.
   always_comb begin
      gov_ext     = GW'(req_governor);
      factor_full = (gov_ext > ONE) ? '0 : (ONE - gov_ext);
      factor      = factor_full[FW-1:0];
   end

   always_comb begin
      cfg_xy.deadzone    = dz_xy_ff;
      cfg_xy.max_turn    = max_turn_ff;
      cfg_xy.accel       = accel_ff;
      cfg_xy.min_speed   = min_y_ff;
      cfg_y              = cfg_xy;
      cfg_turn           = cfg_xy;
      cfg_turn.deadzone  = dz_turn_ff;
   end

   // One lane per axis.
   jdrl_lane #(
      .FRAC_BITS (FRAC_BITS),
      .USE_CLAMP (1'b1),
      .USE_MIN   (1'b0)
   ) u_lane_x (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_xy),
      .cmd    (req_x_cmd),
      .factor (factor),
      .result (out_x)
   );

   jdrl_lane #(
      .FRAC_BITS (FRAC_BITS),
      .USE_CLAMP (1'b0),
      .USE_MIN   (1'b1)
   ) u_lane_y (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_y),
      .cmd    (req_y_cmd),
      .factor (factor),
      .result (out_y)
   );

   jdrl_lane #(
      .FRAC_BITS (FRAC_BITS),
      .USE_CLAMP (1'b1),
      .USE_MIN   (1'b0)
   ) u_lane_turn (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .cfg    (cfg_turn),
      .cmd    (req_turn_cmd),
      .factor (factor),
      .result (out_turn)
   );

   // Merge the lanes into the result register.
   jdrl_merge u_merge (
      .clock                (clock),
      .reset                (reset),
      .commit               (ctrl.commit),
      .lane_x               (out_x),
      .lane_y               (out_y),
      .lane_turn            (out_turn),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_x_conditioned    (rsp_x_conditioned),
      .rsp_y_conditioned    (rsp_y_conditioned),
      .rsp_turn_conditioned (rsp_turn_conditioned),
      .rsp_x_ramped         (rsp_x_ramped),
      .rsp_y_ramped         (rsp_y_ramped),
      .rsp_turn_ramped      (rsp_turn_ramped)
   );

   // A commit never overwrites a result that is still held.
   `JDRL_ASSERT_SAME(a_no_overwrite, clock, reset, ctrl.commit, !(rsp_valid && rsp_stall))
   // A committed item shows up on the result channel next cycle.
   `JDRL_ASSERT_NEXT(a_commit_shows, clock, reset, ctrl.commit, rsp_valid)
   // No new item enters in the cycle after a transfer in.
   `JDRL_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, req_stall)
   // A result taken with nothing new committed leaves the register empty.
   `JDRL_ASSERT_NEXT(a_drain, clock, reset, rsp_valid && !rsp_stall && !ctrl.commit, !rsp_valid)

endmodule

`default_nettype wire

// ===== rtl/core/jdrl_lane.sv =====
// ----------------------------------------------------------------------------
// jdrl_lane
// One axis: deadzone, governor scaling, optional clamp and the ramp limiter
// with its stored last speed.
// ----------------------------------------------------------------------------
`default_nettype none

module jdrl_lane
   import jdrl_pkg::*;
#(
   parameter int FRAC_BITS = 15,
   parameter bit USE_CLAMP = 1'b1,
   parameter bit USE_MIN   = 1'b0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lane_ctrl_type         ctrl,
   input  wire lane_cfg_type          cfg,
   input  wire logic signed [15:0]    cmd,
   input  wire logic [FRAC_BITS:0]    factor,
   output lane_out_type               result
);

   localparam int FW = FRAC_BITS + 1;
   localparam int PW = 16 + FW;
   localparam logic [PW-1:0] HALF_G = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);
   localparam logic [31:0]   HALF_A = 32'd1 << (FRAC_BITS - 1);

   logic [14:0]        mag_ff, mag_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] last_ff, last_in;

   logic [15:0]        cmd_mag;
   logic               keep;
   logic [PW-1:0]      gov_prod;
   logic [PW-1:0]      gov_shr;
   logic [14:0]        gov_mag;
   logic signed [15:0] cond;
   logic signed [15:0] last_eff;
   logic [14:0]        c_mag;
   logic [14:0]        l_mag;
   logic [31:0]        acc_prod;
   logic [31:0]        acc_shr;
   logic [14:0]        acc_mag;
   logic signed [15:0] acc_val;
   logic signed [16:0] sum;
   logic signed [15:0] step;
   logic signed [15:0] step_min;
   logic signed [15:0] min_s;
   logic               step_neg;

   // Ahead of the load register: deadzone, governor product, rounding, saturation and clamp.
   always_comb begin
      cmd_mag  = cmd[15] ? 16'(-cmd) : 16'(cmd);
      keep     = cmd_mag > {1'b0, cfg.deadzone};
      gov_prod = keep ? (PW'(cmd_mag) * PW'(factor)) : '0;
      gov_shr  = (gov_prod + HALF_G) >> FRAC_BITS;
      gov_mag  = (gov_shr > PW'(QMAX)) ? QMAX : gov_shr[14:0];
      mag_in   = gov_mag;
      // The clamp is symmetric, so it acts on the magnitude alone.
      if (USE_CLAMP && (gov_mag > cfg.max_turn)) begin
         mag_in = cfg.max_turn;
      end
      neg_in   = cmd[15] & keep;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         mag_ff <= mag_in;
         neg_ff <= neg_in;
      end
   end

   // From the load register: restore the sign of the conditioned command.
   always_comb begin
      cond = neg_ff ? -$signed({1'b0, mag_ff}) : $signed({1'b0, mag_ff});
   end

   // Ramp: drop the stored speed on a sign change, then limit the step.
   always_comb begin
      if ((cond <= 16'sd0) != (last_ff <= 16'sd0)) begin
         last_eff = 16'sd0;
      end else begin
         last_eff = last_ff;
      end
      c_mag    = mag_ff;
      l_mag    = last_eff[15] ? 15'(-last_eff) : last_eff[14:0];
      acc_prod = 32'(c_mag) * 32'(cfg.accel);
      acc_shr  = (acc_prod + HALF_A) >> FRAC_BITS;
      acc_mag  = (acc_shr > 32'(QMAX)) ? QMAX : acc_shr[14:0];
      acc_val  = cond[15] ? -$signed({1'b0, acc_mag}) : $signed({1'b0, acc_mag});
      sum      = {last_eff[15], last_eff} + {acc_val[15], acc_val};
      if (sum > 17'sd32767) begin
         step = 16'sd32767;
      end else if (sum < -17'sd32767) begin
         step = -16'sd32767;
      end else begin
         step = sum[15:0];
      end

      // Minimum magnitude while accelerating; zero takes the command's sign.
      min_s    = $signed({1'b0, cfg.min_speed});
      step_neg = step[15] | ((step == 16'sd0) & cond[15]);
      step_min = step;
      if (USE_MIN) begin
         if (step_neg && (step > -min_s)) begin
            step_min = -min_s;
         end else if (!step_neg && (step < min_s)) begin
            step_min = min_s;
         end
      end

      if (cond == 16'sd0) begin
         last_in = 16'sd0;
      end else if (c_mag <= l_mag) begin
         last_in = cond;
      end else begin
         last_in = step_min;
      end
   end

   // Stored speed for the next item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= 16'sd0;
      end else if (ctrl.commit) begin
         last_ff <= last_in;
      end
   end

   assign result.cond   = cond;
   assign result.ramped = last_in;

endmodule

`default_nettype wire

// ===== rtl/core/jdrl_merge.sv =====
// ----------------------------------------------------------------------------
// jdrl_merge
// Collects the three lane results into the result register and runs the
// result channel's valid and stall.
// ----------------------------------------------------------------------------
`default_nettype none

module jdrl_merge
   import jdrl_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               commit,
   input  wire lane_out_type       lane_x,
   input  wire lane_out_type       lane_y,
   input  wire lane_out_type       lane_turn,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [15:0]      rsp_x_conditioned,
   output logic signed [15:0]      rsp_y_conditioned,
   output logic signed [15:0]      rsp_turn_conditioned,
   output logic signed [15:0]      rsp_x_ramped,
   output logic signed [15:0]      rsp_y_ramped,
   output logic signed [15:0]      rsp_turn_ramped
);

   logic         valid_ff, valid_in;
   lane_out_type x_ff, y_ff, turn_ff;

   // A commit fills the register; a transfer without a commit empties it.
   always_comb begin
      valid_in = valid_ff;
      if (commit) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         x_ff    <= lane_x;
         y_ff    <= lane_y;
         turn_ff <= lane_turn;
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_x_conditioned    = x_ff.cond;
   assign rsp_y_conditioned    = y_ff.cond;
   assign rsp_turn_conditioned = turn_ff.cond;
   assign rsp_x_ramped         = x_ff.ramped;
   assign rsp_y_ramped         = y_ff.ramped;
   assign rsp_turn_ramped      = turn_ff.ramped;

endmodule

`default_nettype wire
